// File: rtl/tpbl_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the temporal plane blend luma block.
package tpbl_pkg;

    localparam int MAX_PIXELS_DEF   = 131072;
    localparam int NUM_PLANES_DEF   = 32;
    localparam int PLANE_STRIDE_DEF = 8;

    localparam int LUMA_W   = 15;
    localparam int SAMPLE_W = 13;
    localparam int TAPS     = 4;
    localparam int MASK_W   = 16;
    localparam int CFG_DW   = 18;
    localparam int CFG_IW   = 2;

    localparam logic [CFG_IW-1:0] REG_BIT_MASK     = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FRAME_PIXELS = 2'd1;

    localparam logic [MASK_W-1:0] BIT_MASK_RST     = 16'hFCFC;
    localparam int                FRAME_PIXELS_RST = 76800;

endpackage

// File: rtl/temporal_plane_blend_luma_top.sv
`timescale 1ns / 1ps
// Temporal plane blend on a luma stream: row memory of all planes, read-modify-write.
//
//  port group | direction | handshake          | payload
//  s_         | in        | s_valid / s_ready  | s_luma_in[14:0]
//  m_         | out       | m_valid / m_ready  | m_luma_out[14:0], m_frame_end
//  cfg_       | in        | cfg_we             | cfg_index[1:0], cfg_data[17:0]
//
// One item per clock while s_ready is high; each item is registered into the combine
// stage with the read of its plane-memory row; the combine stage fills the queue.
// After reset, and after each write that changes frame_pixels, a clearing pass
// zeroes one memory row per cycle, all MAX_PIXELS rows; s_ready is low meanwhile.
// A two-entry output queue absorbs m_ready stalls; s_ready drops when it would fill.
module temporal_plane_blend_luma_top #(
    parameter int MAX_PIXELS   = tpbl_pkg::MAX_PIXELS_DEF,
    parameter int NUM_PLANES   = tpbl_pkg::NUM_PLANES_DEF,
    parameter int PLANE_STRIDE = tpbl_pkg::PLANE_STRIDE_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tpbl_pkg::LUMA_W-1:0] s_luma_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tpbl_pkg::LUMA_W-1:0] m_luma_out,
    output logic                        m_frame_end,
    input  logic                        cfg_we,
    input  logic [tpbl_pkg::CFG_IW-1:0] cfg_index,
    input  logic [tpbl_pkg::CFG_DW-1:0] cfg_data
);

    localparam int LW   = tpbl_pkg::LUMA_W;
    localparam int SW   = tpbl_pkg::SAMPLE_W;
    localparam int TAPS = tpbl_pkg::TAPS;
    localparam int PW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int FW   = $clog2(MAX_PIXELS + 1);
    localparam int CW   = (FW > tpbl_pkg::CFG_DW) ? FW : tpbl_pkg::CFG_DW;
    localparam int PLW  = $clog2(NUM_PLANES);
    localparam int STW  = $clog2(PLANE_STRIDE);

    localparam logic [FW-1:0]  FP_RST = FW'((tpbl_pkg::FRAME_PIXELS_RST > MAX_PIXELS) ?
                                            MAX_PIXELS : tpbl_pkg::FRAME_PIXELS_RST);
    localparam logic [FW-1:0]  FP_MAX     = FW'(MAX_PIXELS);
    localparam logic [CW-1:0]  FP_MAX_CW  = CW'(MAX_PIXELS);
    localparam logic [PW-1:0]  LAST_ADDR  = PW'(MAX_PIXELS - 1);
    localparam logic [PLW-1:0] LAST_PLANE = PLW'(NUM_PLANES - 1);
    localparam logic [STW-1:0] LAST_START = STW'(PLANE_STRIDE - 1);

    // configuration
    logic [tpbl_pkg::MASK_W-1:0] bit_mask_reg;
    logic [FW-1:0]               frame_pixels_reg;
    logic [CW-1:0]               cfg_ext;
    logic [FW-1:0]               fp_eff;
    logic                        frame_change;
    logic [LW-1:0]               mask;

    // clearing pass
    logic          clr_active_reg;
    logic [PW-1:0] clr_addr_reg;

    // position state
    logic [PW-1:0]  pos_reg;
    logic [PLW-1:0] cur_reg;
    logic [STW-1:0] start_reg;
    logic [PLW-1:0] tap_reg [TAPS];

    // input stage
    logic          accept;
    logic [FW-1:0] pos_inc;
    logic          last0;
    logic          start_zero;
    logic [LW-1:0] x_masked;

    // combine stage
    logic           p1_valid_reg;
    logic [PW-1:0]  p1_pos_reg;
    logic [PLW-1:0] p1_cur_reg;
    logic [SW-1:0]  p1_xs_reg;
    logic           p1_last_reg;
    logic [PLW-1:0] p1_tap_reg [TAPS];

    // plane memory: one row holds every plane at one pixel position
    logic [NUM_PLANES-1:0][SW-1:0] mem [MAX_PIXELS];
    logic [NUM_PLANES-1:0][SW-1:0] rd_row_reg;
    logic [NUM_PLANES-1:0][SW-1:0] fwd_row_reg;
    logic                          fwd_hit_reg;
    logic [NUM_PLANES-1:0][SW-1:0] base_row;
    logic [NUM_PLANES-1:0][SW-1:0] mod_row;
    logic [NUM_PLANES-1:0][SW-1:0] wr_row;
    logic [LW-1:0]                 sum;
    logic [LW-1:0]                 wb_masked;

    // output queue
    logic [LW-1:0] q_luma_reg [2];
    logic          q_fe_reg   [2];
    logic          q_wr_ptr_reg;
    logic          q_rd_ptr_reg;
    logic [1:0]    q_count_reg;
    logic [1:0]    q_occ;
    logic          pop;

    // ---------------------------------------------------------------------
    // Configuration decode
    // ---------------------------------------------------------------------
    assign cfg_ext = CW'(cfg_data);
    assign mask    = bit_mask_reg[LW-1:0];

    always_comb begin
        if (cfg_ext == '0) begin
            fp_eff = FW'(1);
        end else if (cfg_ext > FP_MAX_CW) begin
            fp_eff = FP_MAX;
        end else begin
            fp_eff = FW'(cfg_ext);
        end
    end

    assign frame_change = cfg_we && (cfg_index == tpbl_pkg::REG_FRAME_PIXELS) &&
                          (fp_eff != frame_pixels_reg);

    // ---------------------------------------------------------------------
    // Input stage
    // ---------------------------------------------------------------------
    assign pop     = m_valid && m_ready;
    assign q_occ   = q_count_reg - {1'b0, pop} + {1'b0, p1_valid_reg};
    assign s_ready = !clr_active_reg && (q_occ < 2'd2);
    assign accept  = s_valid && s_ready;

    assign pos_inc    = FW'(pos_reg) + FW'(1);
    assign last0      = (pos_inc >= frame_pixels_reg);
    assign start_zero = (cur_reg == LAST_PLANE) || (start_reg == LAST_START);
    assign x_masked   = s_luma_in & mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_mask_reg     <= tpbl_pkg::BIT_MASK_RST;
            frame_pixels_reg <= FP_RST;
            clr_active_reg   <= 1'b1;
            clr_addr_reg     <= '0;
            pos_reg          <= '0;
            cur_reg          <= '0;
            start_reg        <= '0;
            p1_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
        end else begin
            if (cfg_we && (cfg_index == tpbl_pkg::REG_BIT_MASK)) begin
                bit_mask_reg <= cfg_data[tpbl_pkg::MASK_W-1:0];
            end
            p1_valid_reg <= accept;
            fwd_hit_reg  <= accept && p1_valid_reg && (p1_pos_reg == pos_reg);
            if (frame_change) begin
                frame_pixels_reg <= fp_eff;
                clr_active_reg   <= 1'b1;
                clr_addr_reg     <= '0;
                pos_reg          <= '0;
                cur_reg          <= '0;
                start_reg        <= '0;
            end else if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + PW'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    clr_active_reg <= 1'b0;
                end
            end else if (accept) begin
                if (last0) begin
                    pos_reg   <= '0;
                    cur_reg   <= (cur_reg == LAST_PLANE) ? '0 : cur_reg + PLW'(1);
                    start_reg <= start_zero ? '0 : start_reg + STW'(1);
                end else begin
                    pos_reg <= PW'(pos_inc);
                end
            end
        end
    end

    // Tap planes follow the start plane: step with it, or reload on wrap.
    for (genvar g = 0; g < TAPS; g++) begin : g_tap
        localparam logic [PLW-1:0] TAP_BASE = PLW'((g * PLANE_STRIDE) % NUM_PLANES);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tap_reg[g] <= TAP_BASE;
            end else if (frame_change) begin
                tap_reg[g] <= TAP_BASE;
            end else if (accept && last0 && !clr_active_reg) begin
                if (start_zero) begin
                    tap_reg[g] <= TAP_BASE;
                end else begin
                    tap_reg[g] <= (tap_reg[g] == LAST_PLANE) ? '0 : tap_reg[g] + PLW'(1);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (accept) begin
                p1_tap_reg[g] <= tap_reg[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_pos_reg  <= pos_reg;
            p1_cur_reg  <= cur_reg;
            p1_xs_reg   <= x_masked[LW-1:2];
            p1_last_reg <= last0;
        end
        fwd_row_reg <= wr_row;
    end

    // ---------------------------------------------------------------------
    // Plane memory (read-first)
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (p1_valid_reg) begin
            mem[p1_pos_reg] <= wr_row;
        end
        rd_row_reg <= mem[pos_reg];
    end

    // ---------------------------------------------------------------------
    // Combine stage
    // ---------------------------------------------------------------------
    always_comb begin
        // take the row just written when the previous item hit the same pixel
        base_row              = fwd_hit_reg ? fwd_row_reg : rd_row_reg;
        mod_row               = base_row;
        mod_row[p1_cur_reg]   = p1_xs_reg;
        sum                   = '0;
        for (int k = 0; k < TAPS; k++) begin
            sum = sum + LW'(mod_row[p1_tap_reg[k]]);
        end
        wb_masked             = sum & mask;
        wr_row                = mod_row;
        wr_row[p1_cur_reg]    = wb_masked[LW-1:2];
    end

    // ---------------------------------------------------------------------
    // Output queue
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            q_luma_reg[q_wr_ptr_reg] <= sum;
            q_fe_reg[q_wr_ptr_reg]   <= p1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_count_reg  <= '0;
        end else begin
            if (p1_valid_reg) begin
                q_wr_ptr_reg <= !q_wr_ptr_reg;
            end
            if (pop) begin
                q_rd_ptr_reg <= !q_rd_ptr_reg;
            end
            q_count_reg <= q_occ;
        end
    end

    assign m_valid     = (q_count_reg != 2'd0);
    assign m_luma_out  = q_luma_reg[q_rd_ptr_reg];
    assign m_frame_end = q_fe_reg[q_rd_ptr_reg];

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg != 2'd3)
        else $error("output queue overfilled");

    a_fwd_source: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> ($past(p1_valid_reg) && $past(accept)))
        else $error("forwarding without a preceding write");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && last0) |=> (pos_reg == '0))
        else $error("pixel position not rewound at frame end");

    a_plane_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_reg <= LAST_PLANE) && (tap_reg[0] <= LAST_PLANE))
        else $error("plane index out of range");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the temporal plane blend luma block.

typedef struct packed {
    logic [14:0] luma;
    logic        frame_end;
} blend_result_t;

class luma_blend_scoreboard;
    logic [12:0]   plane_mem [int];
    logic [4:0]    plane_idx;
    logic [16:0]   pix_pos;
    logic [15:0]   mask;
    logic [17:0]   frame_len;
    blend_result_t blended_q [$];
    int            errors;

    function new();
        errors    = 0;
        mask      = tpbl_pkg::BIT_MASK_RST;
        frame_len = 18'(tpbl_pkg::FRAME_PIXELS_RST);
        clear_planes();
    endfunction

    function void clear_planes();
        plane_mem.delete();
        plane_idx = '0;
        pix_pos   = '0;
    endfunction

    function int plane_addr(logic [4:0] plane, logic [16:0] pos);
        return int'(plane) * tpbl_pkg::MAX_PIXELS_DEF + int'(pos);
    endfunction

    // Entries never written read as zero, as after a clear
    function logic [12:0] read_sample(logic [4:0] plane, logic [16:0] pos);
        int a;
        a = plane_addr(plane, pos);
        return plane_mem.exists(a) ? plane_mem[a] : 13'd0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [17:0] data);
        logic [17:0] len;
        if (idx == tpbl_pkg::REG_BIT_MASK) begin
            mask = data[15:0];
        end else if (idx == tpbl_pkg::REG_FRAME_PIXELS) begin
            len = data;
            if (len == 18'd0)
                len = 18'd1;
            else if (int'(len) > tpbl_pkg::MAX_PIXELS_DEF)
                len = 18'(tpbl_pkg::MAX_PIXELS_DEF);
            // Only a real change of frame size wipes the planes
            if (len != frame_len) begin
                frame_len = len;
                clear_planes();
            end
        end
    endfunction

    function void note_pixel(logic [14:0] px);
        logic [14:0]   m;
        logic [16:0]   pos;
        logic [4:0]    tap_plane;
        int            acc;
        int            cur_addr;
        int            k;
        blend_result_t r;
        m   = mask[14:0];
        pos = (int'(pix_pos) >= int'(frame_len)) ? 17'd0 : pix_pos;
        cur_addr = plane_addr(plane_idx, pos);
        plane_mem[cur_addr] = 13'((px & m) >> 2);
        acc = 0;
        for (k = 0; k < tpbl_pkg::TAPS; k++) begin
            // 5-bit truncation wraps round the 32 planes
            tap_plane = 5'(int'(plane_idx[2:0]) + k * tpbl_pkg::PLANE_STRIDE_DEF);
            acc += int'(read_sample(tap_plane, pos));
        end
        r.luma = 15'(acc);
        plane_mem[cur_addr] = 13'((r.luma & m) >> 2);
        r.frame_end = (int'(pos) + 1 >= int'(frame_len));
        if (r.frame_end) begin
            pix_pos   = '0;
            plane_idx = plane_idx + 5'd1;
        end else begin
            pix_pos = pos + 17'd1;
        end
        blended_q.push_back(r);
    endfunction

    function void check_result(logic [14:0] luma, logic frame_end);
        blend_result_t e;
        if (blended_q.size() == 0) begin
            $error("unexpected item: luma_out=%0d frame_end=%0d", luma, frame_end);
            errors++;
            return;
        end
        e = blended_q.pop_front();
        if (luma !== e.luma) begin
            $error("luma_out: expected %0d, actual %0d", e.luma, luma);
            errors++;
        end
        if (frame_end !== e.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", e.frame_end, frame_end);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT      = 3_000_000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int MODE_B_START     = 583;
    localparam int MODE_C_START     = 1166;
    localparam int HOLD_AT          = 1300;

    localparam logic [1:0]  REG_SPARE_2 = 2'd2;
    localparam logic [1:0]  REG_SPARE_3 = 2'd3;
    localparam logic [17:0] FRAME_MAX   = 18'(tpbl_pkg::MAX_PIXELS_DEF);
    localparam logic [14:0] EDGE_LUMA [6] = '{15'h0000, 15'h7FFF, 15'h5555,
                                               15'h2AAA, 15'h0001, 15'h4000};

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [tpbl_pkg::LUMA_W-1:0]   s_luma_in;
    logic                          m_valid;
    logic                          m_ready;
    logic [tpbl_pkg::LUMA_W-1:0]   m_luma_out;
    logic                          m_frame_end;
    logic                          cfg_we;
    logic [tpbl_pkg::CFG_IW-1:0]   cfg_index;
    logic [tpbl_pkg::CFG_DW-1:0]   cfg_data;

    int cycle_count  = 0;
    int random_sent  = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    bit rx_hold_req  = 1'b0;

    luma_blend_scoreboard blend;

    temporal_plane_blend_luma_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_luma_in   (s_luma_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_luma_out  (m_luma_out),
        .m_frame_end (m_frame_end),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            blend.check_result(m_luma_out, m_frame_end);
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                rx_hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_pixel(input logic [14:0] px);
        @(negedge aclk);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid   <= 1'b1;
        s_luma_in <= px;
        do @(posedge aclk); while (!s_ready);
        blend.note_pixel(px);
    endtask

    task automatic send_random(input int count);
        int          i;
        int          pick;
        logic [14:0] px;
        for (i = 0; i < count; i++) begin
            if (random_sent < MODE_B_START) begin
                tx_idle_pct = 26;
                rx_idle_pct = 64;
            end else if (random_sent < MODE_C_START) begin
                tx_idle_pct = 64;
                rx_idle_pct = 26;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (random_sent == HOLD_AT)
                rx_hold_req = 1'b1;
            pick = $urandom_range(0, 7);
            px = (pick == 0) ? 15'h0000 :
                 (pick == 1) ? 15'h7FFF : 15'($urandom_range(0, 32767));
            send_pixel(px);
            random_sent++;
        end
    endtask

    // Drop valid and wait until every expected item has come out
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (blend.blended_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [17:0] data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        blend.write_reg(idx, data);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_luma_in = '0;
        m_ready   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = tpbl_pkg::REG_BIT_MASK;
        cfg_data  = '0;
        blend     = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Reset settings: long frames, so no frame ends here
        foreach (EDGE_LUMA[i]) send_pixel(EDGE_LUMA[i]);
        send_random(150);

        // Single-pixel frames: every item ends a frame; mask bit 15 set
        write_reg(tpbl_pkg::REG_BIT_MASK, 18'h0FFFF);
        write_reg(tpbl_pkg::REG_FRAME_PIXELS, 18'd1);
        // Zero maps to one pixel, so the planes must survive this write
        write_reg(tpbl_pkg::REG_FRAME_PIXELS, 18'd0);
        // Unused indexes: ignored, whichever register they resemble
        write_reg(REG_SPARE_2, 18'h00005);
        write_reg(REG_SPARE_3, 18'h00003);
        foreach (EDGE_LUMA[i]) send_pixel(EDGE_LUMA[i]);
        send_random(400);

        write_reg(tpbl_pkg::REG_BIT_MASK, 18'($urandom_range(0, 65535)));
        write_reg(tpbl_pkg::REG_FRAME_PIXELS, 18'd7);
        send_random(500);

        // Largest frame; an oversized write then saturates to the same size
        write_reg(tpbl_pkg::REG_BIT_MASK, 18'h07FFF);
        write_reg(tpbl_pkg::REG_FRAME_PIXELS, FRAME_MAX);
        write_reg(tpbl_pkg::REG_FRAME_PIXELS, 18'h3FFFF);
        send_random(150);

        write_reg(tpbl_pkg::REG_BIT_MASK, 18'h00000);
        write_reg(tpbl_pkg::REG_FRAME_PIXELS, 18'd3);
        send_random(50);
        write_reg(tpbl_pkg::REG_BIT_MASK, 18'($urandom_range(0, 65535)));
        send_random(500);

        drain_results();
        if (blend.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
